/* hdl/ssrn_pkg.sv */
// shared types and constants for the sensor smoothing and range normalization block
`timescale 1ns / 1ps
package ssrn_pkg;

  localparam int          CHANNELS_DEF = 7;
  localparam logic [15:0] WEIGHT_RESET = 16'd9830;
  localparam int          DIV_STEPS    = 16;
  localparam int          CNT_W        = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_CMP,
    ST_DIFF,
    ST_SPAN,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } ssrn_state_t;

endpackage

/* hdl/sensor_smooth_range_normalize.sv */
// top level: per-channel moving average, running range and normalized position
// path: a taken request passes multiply, add, compare, difference, span, setup, divide and finish
// one request at a time; finish waits while an earlier result is not yet taken
// the restoring divider is shared by all channels and gives one quotient bit a cycle
// reset (rst, synchronous): weight back to 9830, all channels marked empty, no result pending
`timescale 1ns / 1ps
module sensor_smooth_range_normalize #(
  parameter int CHANNELS = ssrn_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [15:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [2:0]  channel,
  input  logic signed [15:0] sample,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [2:0]  out_channel,
  output logic signed [31:0] smoothed,
  output logic signed [31:0] lowest,
  output logic signed [31:0] highest,
  output logic signed [15:0] normalized,
  output logic               span_zero,
  output logic               initialized_now
);
  import ssrn_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ssrn_state_t state, state_next;

  logic [15:0] weight;

  // per-channel stores
  logic signed [31:0] avg_mem [CHANNELS];
  logic signed [31:0] lo_mem  [CHANNELS];
  logic signed [31:0] hi_mem  [CHANNELS];
  logic [CHANNELS-1:0] chan_ready;

  logic [IDX_W-1:0]   in_idx, idx;
  logic               in_range_in;
  logic [2:0]         ch_q;
  logic signed [15:0] samp_q;
  logic               init_q;
  logic               in_range;
  logic signed [31:0] old_avg, old_lo, old_hi;
  logic signed [49:0] prod;
  logic signed [31:0] avg, lo, hi;
  logic        [32:0] dlo, dhi, mag, span;
  logic               neg, zero;
  logic        [49:0] rem;
  logic        [48:0] dsh;
  logic        [15:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               fin_load;

  logic signed [31:0] target;
  logic signed [32:0] diff;
  logic signed [49:0] rnd_biased;
  logic signed [31:0] avg_next;
  logic        [15:0] nrm_out;

  assign cfg_ready   = 1'b1;
  assign in_idx      = IDX_W'(channel);
  assign idx         = IDX_W'(ch_q);
  assign in_range_in = int'(channel) < CHANNELS;

  assign target     = {samp_q, 16'd0};
  assign diff       = {target[31], target} - {old_avg[31], old_avg};
  // round to nearest, ties up, then arithmetic shift by 16
  assign rnd_biased = prod + 50'sd32768;
  assign avg_next   = init_q ? target : old_avg + rnd_biased[47:16];

  always_comb begin
    if (zero) begin
      nrm_out = '0;
    end else if (neg) begin
      nrm_out = ~quo + 16'd1;
    end else if (quo[15]) begin
      nrm_out = 16'h7fff;
    end else begin
      nrm_out = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    fin_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_CMP;
      ST_CMP:   state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_SPAN;
      ST_SPAN:  state_next = ST_SETUP;
      ST_SETUP: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == '0) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          fin_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weight <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_ready <= '0;
    end else if (state == ST_CMP && in_range) begin
      chan_ready[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // store read on request, write back once min and max are known
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && in_range_in) begin
      old_avg <= avg_mem[in_idx];
      old_lo  <= lo_mem[in_idx];
      old_hi  <= hi_mem[in_idx];
    end
    if (state == ST_CMP && in_range) begin
      avg_mem[idx] <= avg;
      lo_mem[idx]  <= (init_q || avg < old_lo) ? avg : old_lo;
      hi_mem[idx]  <= (init_q || avg > old_hi) ? avg : old_hi;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        ch_q     <= channel;
        samp_q   <= sample;
        in_range <= in_range_in;
        init_q   <= restart || !in_range_in || !chan_ready[in_idx];
      end
      ST_MUL: prod <= diff * $signed({1'b0, weight});
      ST_ADD: avg  <= avg_next;
      ST_CMP: begin
        lo <= (init_q || avg < old_lo) ? avg : old_lo;
        hi <= (init_q || avg > old_hi) ? avg : old_hi;
      end
      ST_DIFF: begin
        dlo <= {avg[31], avg} - {lo[31], lo};
        dhi <= {hi[31], hi} - {avg[31], avg};
      end
      ST_SPAN: begin
        // numerator 2*avg - lo - hi is dlo - dhi, span is dlo + dhi
        neg  <= dhi > dlo;
        mag  <= (dlo >= dhi) ? dlo - dhi : dhi - dlo;
        span <= dlo + dhi;
      end
      ST_SETUP: begin
        zero <= span == '0;
        rem  <= {mag, 16'd0} + {17'd0, span};
        dsh  <= {span, 16'd0};
        quo  <= '0;
        cnt  <= CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        if (rem >= {1'b0, dsh}) begin
          rem <= rem - {1'b0, dsh};
          quo <= {quo[14:0], 1'b1};
        end else begin
          quo <= {quo[14:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      ST_FIN: begin
        if (fin_load) begin
          out_channel <= ch_q;
          if (in_range) begin
            smoothed        <= avg;
            lowest          <= lo;
            highest         <= hi;
            normalized      <= nrm_out;
            span_zero       <= zero;
            initialized_now <= init_q;
          end else begin
            smoothed        <= '0;
            lowest          <= '0;
            highest         <= '0;
            normalized      <= '0;
            span_zero       <= 1'b0;
            initialized_now <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/ssrn_check.sv */
// port-level checks for the sensor smoothing block and their bind
`timescale 1ns / 1ps
module ssrn_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] smoothed,
  input logic signed [31:0] lowest,
  input logic signed [31:0] highest,
  input logic signed [15:0] normalized,
  input logic               span_zero,
  input logic               initialized_now
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(smoothed) && $stable(normalized))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lowest <= highest)
    else $error("minimum above maximum");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && span_zero |-> lowest == highest && normalized == 16'sd0)
    else $error("zero span flag inconsistent");

  a_init: assert property (@(posedge clk) disable iff (rst)
    out_valid && initialized_now |-> span_zero && smoothed == lowest)
    else $error("initialized channel has a span");

endmodule

bind sensor_smooth_range_normalize ssrn_check u_ssrn_check (.*);
